// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk_i, off while rst_ni is low
`define BM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define BM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bm3_pkg.sv =====
package bm3_pkg;

  // line store depth and frame height limit
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;

  localparam int FrameWidthW  = 11;
  localparam int FrameHeightW = 12;
  localparam int ColW   = $clog2(MaxWidth);
  localparam int RowW   = $clog2(MaxHeight);
  localparam int EffWW  = $clog2(MaxWidth + 1);
  localparam int EffHW  = $clog2(MaxHeight + 1);
  localparam int CntW   = $clog2(MaxWidth + 2);

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  // line store word: bit 1 row above, bit 0 middle row
  localparam int LineW = 2;

  localparam logic [FrameWidthW-1:0]  FrameWidthRst  = FrameWidthW'(640);
  localparam logic [FrameHeightW-1:0] FrameHeightRst = FrameHeightW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth   = 3'd0,
    CfgFrameHeight  = 3'd1,
    CfgOperation    = 3'd2,
    CfgConnectivity = 3'd3,
    CfgErodeEdge    = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OpErode  = 1'b0,
    OpDilate = 1'b1
  } op_e;

  typedef enum logic {
    Conn4 = 1'b0,
    Conn8 = 1'b1
  } conn_e;

  typedef enum logic {
    ModePixel = 1'b0,
    ModeFlush = 1'b1
  } mode_e;

  typedef struct packed {
    op_e   operation;
    conn_e connectivity;
    logic  erode_edge;
  } cfg_t;

  typedef struct packed {
    logic mode;
    logic pixel_in;
  } in_item_t;

  typedef struct packed {
    logic pixel_out;
    logic changed;
    logic frame_end;
  } out_item_t;

  // 3x3 neighbourhood, [row][col], row 0 above, col 0 left
  typedef logic [2:0][2:0] nb_t;

endpackage

// ===== rtl/bm3_ram.sv =====
module bm3_ram #(
  parameter int Depth = 1024,
  parameter int DataW = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [DataW-1:0]         rdata_a_o,
  output logic [DataW-1:0]         rdata_b_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_a_q;
  logic [DataW-1:0] rdata_b_q;

  // write-first: a read of the address being written returns the new word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= (we_i && waddr_i == raddr_a_i) ? wdata_i : mem_q[raddr_a_i];
    rdata_b_q <= (we_i && waddr_i == raddr_b_i) ? wdata_i : mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/bm3_decide.sv =====
module bm3_decide (
  input  bm3_pkg::nb_t                 nb_i,
  input  logic [bm3_pkg::RowW-1:0]     row_i,
  input  logic [bm3_pkg::ColW-1:0]     col_i,
  input  logic [bm3_pkg::EffWW-1:0]    w_i,
  input  logic [bm3_pkg::EffHW-1:0]    h_i,
  input  bm3_pkg::cfg_t                cfg_i,
  output bm3_pkg::out_item_t           res_o
);

  logic [bm3_pkg::EffHW-1:0] r_ext;
  logic [bm3_pkg::EffWW-1:0] c_ext;
  logic [2:0] row_ok;
  logic [2:0] col_ok;
  logic       centre;
  logic       any_fg;
  logic       all_fg;
  logic       border;
  logic       res;

  assign r_ext  = bm3_pkg::EffHW'(row_i);
  assign c_ext  = bm3_pkg::EffWW'(col_i);
  assign centre = nb_i[1][1];

  // neighbour rows and columns that lie inside the frame
  assign row_ok[0] = (r_ext != '0) && (r_ext <= h_i);
  assign row_ok[1] = r_ext < h_i;
  assign row_ok[2] = (r_ext + bm3_pkg::EffHW'(1)) < h_i;
  assign col_ok[0] = (c_ext != '0) && (c_ext <= w_i);
  assign col_ok[1] = c_ext < w_i;
  assign col_ok[2] = (c_ext + bm3_pkg::EffWW'(1)) < w_i;

  assign border = (r_ext == '0) || (c_ext == '0) ||
                  ((r_ext + bm3_pkg::EffHW'(1)) >= h_i) ||
                  ((c_ext + bm3_pkg::EffWW'(1)) >= w_i);

  always_comb begin
    any_fg = 1'b0;
    all_fg = 1'b1;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if (!(dr == 1 && dc == 1) &&
            (cfg_i.connectivity == bm3_pkg::Conn8 || dr == 1 || dc == 1) &&
            row_ok[dr] && col_ok[dc]) begin
          if (nb_i[dr][dc]) begin
            any_fg = 1'b1;
          end else begin
            all_fg = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    if (cfg_i.operation == bm3_pkg::OpDilate) begin
      res = centre | any_fg;
    end else if (cfg_i.erode_edge && border) begin
      res = 1'b0;
    end else begin
      res = centre & all_fg;
    end
  end

  assign res_o.pixel_out = res;
  assign res_o.changed   = res ^ centre;
  assign res_o.frame_end = ((r_ext + bm3_pkg::EffHW'(1)) == h_i) &&
                           ((c_ext + bm3_pkg::EffWW'(1)) == w_i);

endmodule

// ===== rtl/bm3_out_buf.sv =====
`include "assert_macros.svh"

module bm3_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bm3_pkg::out_item_t data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bm3_pkg::out_item_t out_data_o
);

  logic               head_v_q, head_v_d;
  logic               skid_v_q, skid_v_d;
  bm3_pkg::out_item_t head_q, head_d;
  bm3_pkg::out_item_t skid_q, skid_d;
  logic               pop;

  assign pop = head_v_q & ~out_stall_i;

  always_comb begin
    head_v_d = head_v_q;
    head_d   = head_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        skid_v_d = 1'b0;
      end else if (push_i) begin
        head_d = data_i;
      end else begin
        head_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!head_v_q) begin
        head_v_d = 1'b1;
        head_d   = data_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = head_v_q;
  assign out_data_o  = head_q;

  `BM_ASSERT(a_skid_needs_head, skid_v_q |-> head_v_q, "skid holds an item while head is empty")
  `BM_ASSERT(a_no_push_when_full, push_i |-> !skid_v_q, "result pushed into a full buffer")

endmodule

// ===== rtl/binary_morphology_3x3.sv =====
// release: a result is pushed into the output buffer when the item that releases it is taken,
//   i.e. the pixel W + 1 items later in raster order, or a flush item at the frame tail
// throughput: one item per cycle while in_stall_o is low, set by the single write-first line store update per item
// reset: registers to their reset values, then a clearing sweep over all MaxWidth (1024) line store entries,
//   with in_stall_o high; configuration writes are taken throughout
`include "assert_macros.svh"

module binary_morphology_3x3 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel and flush items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bm3_pkg::in_item_t              in_data_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bm3_pkg::out_item_t             out_data_o,
  // register writes
  input  logic                           cfg_we_i,
  input  logic [bm3_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bm3_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  // configuration registers
  logic [bm3_pkg::FrameWidthW-1:0]  frame_width_q;
  logic [bm3_pkg::FrameHeightW-1:0] frame_height_q;
  bm3_pkg::cfg_t                    cfg_q;

  // effective frame size after clamping
  logic [bm3_pkg::EffWW-1:0] eff_w;
  logic [bm3_pkg::EffHW-1:0] eff_h;
  logic [bm3_pkg::CntW-1:0]  w_plus1;

  // line store clearing sweep after reset
  logic                    clr_busy_q;
  logic [bm3_pkg::ColW-1:0] clr_addr_q;

  // stream position, warm-up and tail drain bookkeeping
  logic [bm3_pkg::ColW-1:0] in_col_q,  in_col_d;
  logic [bm3_pkg::RowW-1:0] in_row_q,  in_row_d;
  logic [bm3_pkg::ColW-1:0] out_col_q, out_col_d;
  logic [bm3_pkg::RowW-1:0] out_row_q, out_row_d;
  logic [bm3_pkg::CntW-1:0] fill_q,    fill_d;
  logic [bm3_pkg::CntW-1:0] drained_q, drained_d;
  bm3_pkg::nb_t             win_q,     win_d;
  logic                     lo_oob_q;
  logic                     hi_oob_q;

  // handshake
  logic in_acc;
  logic is_flush;
  logic flush_ok;
  logic pix_acc;
  logic flush_acc;
  logic res_valid;
  logic buf_full;

  // line store access
  logic                       mem_we;
  logic [bm3_pkg::ColW-1:0]   mem_waddr;
  logic [bm3_pkg::LineW-1:0]  mem_wdata;
  logic [bm3_pkg::LineW-1:0]  line_cur;   // at in_col_q, for the pixel path
  logic [bm3_pkg::LineW-1:0]  line_ctr;   // at out_col_q
  logic [bm3_pkg::LineW-1:0]  line_lft;   // at out_col_q - 1
  logic [bm3_pkg::LineW-1:0]  line_rgt;   // at out_col_q + 1

  bm3_pkg::nb_t       win_shift;
  bm3_pkg::nb_t       flush_nb;
  bm3_pkg::nb_t       nb_sel;
  bm3_pkg::out_item_t res;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q      <= bm3_pkg::FrameWidthRst;
      frame_height_q     <= bm3_pkg::FrameHeightRst;
      cfg_q.operation    <= bm3_pkg::OpErode;
      cfg_q.connectivity <= bm3_pkg::Conn8;
      cfg_q.erode_edge   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (bm3_pkg::cfg_reg_e'(cfg_idx_i))
        bm3_pkg::CfgFrameWidth:   frame_width_q  <= cfg_wdata_i[bm3_pkg::FrameWidthW-1:0];
        bm3_pkg::CfgFrameHeight:  frame_height_q <= cfg_wdata_i[bm3_pkg::FrameHeightW-1:0];
        bm3_pkg::CfgOperation:    cfg_q.operation    <= bm3_pkg::op_e'(cfg_wdata_i[0]);
        bm3_pkg::CfgConnectivity: cfg_q.connectivity <= bm3_pkg::conn_e'(cfg_wdata_i[0]);
        bm3_pkg::CfgErodeEdge:    cfg_q.erode_edge   <= cfg_wdata_i[0];
        default: ;  // unused register index, write dropped
      endcase
    end
  end

  // width clamped to [2, MaxWidth], height to [2, MaxHeight]
  always_comb begin
    if (frame_width_q < bm3_pkg::FrameWidthW'(2)) begin
      eff_w = bm3_pkg::EffWW'(2);
    end else if (int'(frame_width_q) > bm3_pkg::MaxWidth) begin
      eff_w = bm3_pkg::EffWW'(bm3_pkg::MaxWidth);
    end else begin
      eff_w = bm3_pkg::EffWW'(frame_width_q);
    end
    if (frame_height_q < bm3_pkg::FrameHeightW'(2)) begin
      eff_h = bm3_pkg::EffHW'(2);
    end else if (int'(frame_height_q) > bm3_pkg::MaxHeight) begin
      eff_h = bm3_pkg::EffHW'(bm3_pkg::MaxHeight);
    end else begin
      eff_h = bm3_pkg::EffHW'(frame_height_q);
    end
  end

  // warm-up length and tail length, both W + 1
  assign w_plus1 = bm3_pkg::CntW'(eff_w) + bm3_pkg::CntW'(1);

  // ---------------------------------------------------------------------------
  // clearing sweep: one line store entry per cycle, items held off meanwhile
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == bm3_pkg::ColW'(bm3_pkg::MaxWidth - 1)) begin
        clr_busy_q <= 1'b0;
        clr_addr_q <= '0;
      end else begin
        clr_addr_q <= clr_addr_q + bm3_pkg::ColW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item handshake
  // ---------------------------------------------------------------------------
  assign in_stall_o = clr_busy_q | buf_full;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_flush   = in_data_i.mode == bm3_pkg::ModeFlush;

  // a flush only counts at a frame start, after warm-up, with tail left to drain
  assign flush_ok = (in_row_q == '0) && (in_col_q == '0) &&
                    (fill_q >= w_plus1) && (drained_q < w_plus1);

  assign pix_acc   = in_acc & ~is_flush;
  assign flush_acc = in_acc & is_flush & flush_ok;

  // ---------------------------------------------------------------------------
  // neighbourhoods
  // ---------------------------------------------------------------------------
  // pixel item: window moves one column left, new column from the line stores and the input pixel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_shift[i][0] = win_q[i][1];
      win_shift[i][1] = win_q[i][2];
    end
    win_shift[0][2] = line_cur[1];
    win_shift[1][2] = line_cur[0];
    win_shift[2][2] = in_data_i.pixel_in;
  end

  // flush item: last output row reads the two stored rows around out_col,
  // earlier rows reuse the window; missing row or column reads as background
  always_comb begin
    flush_nb = '0;
    if ((bm3_pkg::EffHW'(out_row_q) + bm3_pkg::EffHW'(1)) >= eff_h) begin
      flush_nb[0][0] = line_lft[1] & ~lo_oob_q;
      flush_nb[1][0] = line_lft[0] & ~lo_oob_q;
      flush_nb[0][1] = line_ctr[1];
      flush_nb[1][1] = line_ctr[0];
      flush_nb[0][2] = line_rgt[1] & ~hi_oob_q;
      flush_nb[1][2] = line_rgt[0] & ~hi_oob_q;
    end else begin
      for (int i = 0; i < 3; i++) begin
        flush_nb[i][0] = win_q[i][1];
        flush_nb[i][1] = win_q[i][2];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // position, warm-up and drain state
  // ---------------------------------------------------------------------------
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    fill_d    = fill_q;
    drained_d = drained_q;
    win_d     = win_q;
    res_valid = 1'b0;
    nb_sel    = win_shift;

    if (pix_acc) begin
      win_d = win_shift;
      if ((bm3_pkg::EffWW'(in_col_q) + bm3_pkg::EffWW'(1)) >= eff_w) begin
        in_col_d = '0;
        if ((bm3_pkg::EffHW'(in_row_q) + bm3_pkg::EffHW'(1)) >= eff_h) begin
          in_row_d = '0;
        end else begin
          in_row_d = in_row_q + bm3_pkg::RowW'(1);
        end
      end else begin
        in_col_d = in_col_q + bm3_pkg::ColW'(1);
      end
      // warm-up, then skip outputs already drained by flushes
      if (fill_q < w_plus1) begin
        fill_d = fill_q + bm3_pkg::CntW'(1);
      end else if (drained_q != '0) begin
        drained_d = drained_q - bm3_pkg::CntW'(1);
      end else begin
        res_valid = 1'b1;
      end
    end

    if (flush_acc) begin
      drained_d = drained_q + bm3_pkg::CntW'(1);
      res_valid = 1'b1;
      nb_sel    = flush_nb;
    end

    if (res_valid) begin
      if ((bm3_pkg::EffWW'(out_col_q) + bm3_pkg::EffWW'(1)) >= eff_w) begin
        out_col_d = '0;
        if ((bm3_pkg::EffHW'(out_row_q) + bm3_pkg::EffHW'(1)) >= eff_h) begin
          out_row_d = '0;
        end else begin
          out_row_d = out_row_q + bm3_pkg::RowW'(1);
        end
      end else begin
        out_col_d = out_col_q + bm3_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      fill_q    <= '0;
      drained_q <= '0;
      win_q     <= '0;
      lo_oob_q  <= 1'b1;
      hi_oob_q  <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      fill_q    <= fill_d;
      drained_q <= drained_d;
      win_q     <= win_d;
      // columns left of 0 and right of the last store entry read as background
      lo_oob_q  <= out_col_d == '0;
      hi_oob_q  <= out_col_d == bm3_pkg::ColW'(bm3_pkg::MaxWidth - 1);
    end
  end

  // ---------------------------------------------------------------------------
  // line stores: two copies with the same writes, four reads per cycle,
  // each addressed by the next position so the data is ready for the next item
  // ---------------------------------------------------------------------------
  assign mem_we    = clr_busy_q | pix_acc;
  assign mem_waddr = clr_busy_q ? clr_addr_q : in_col_q;
  // middle row moves up, new pixel becomes the middle row
  assign mem_wdata = clr_busy_q ? '0 : {line_cur[0], in_data_i.pixel_in};

  bm3_ram #(
    .Depth (bm3_pkg::MaxWidth),
    .DataW (bm3_pkg::LineW)
  ) u_line_a (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (in_col_d),
    .raddr_b_i (out_col_d),
    .rdata_a_o (line_cur),
    .rdata_b_o (line_ctr)
  );

  bm3_ram #(
    .Depth (bm3_pkg::MaxWidth),
    .DataW (bm3_pkg::LineW)
  ) u_line_b (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (out_col_d - bm3_pkg::ColW'(1)),
    .raddr_b_i (out_col_d + bm3_pkg::ColW'(1)),
    .rdata_a_o (line_lft),
    .rdata_b_o (line_rgt)
  );

  // ---------------------------------------------------------------------------
  // decision and output register
  // ---------------------------------------------------------------------------
  bm3_decide u_decide (
    .nb_i  (nb_sel),
    .row_i (out_row_q),
    .col_i (out_col_q),
    .w_i   (eff_w),
    .h_i   (eff_h),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  bm3_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `BM_ASSERT(a_clear_blocks_items, clr_busy_q |-> in_stall_o, "item taken during clearing sweep")
  `BM_ASSERT(a_clear_full_sweep, $fell(clr_busy_q) |-> clr_addr_q == '0, "clearing sweep cut short")
  `BM_ASSERT_NEXT(a_result_reaches_out, res_valid, out_valid_o, "result lost before output")

endmodule
